>>> src/clcd_pkg.sv
// Shared types, codes and constants for the character-LCD four-bit sequencer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package clcd_pkg;

  // Request kinds
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_CLEAR  = 3'd1;
  localparam logic [2:0] KIND_HOME   = 3'd2;
  localparam logic [2:0] KIND_CMD    = 3'd3;
  localparam logic [2:0] KIND_CHAR   = 3'd4;
  localparam logic [2:0] KIND_CURSOR = 3'd5;
  localparam logic [2:0] KIND_INT    = 3'd6;
  localparam logic [2:0] KIND_GLYPH  = 3'd7;

  // Wait classes after an enable pulse
  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_SHORT = 2'd1;
  localparam logic [1:0] WAIT_LONG  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FUNCTION_SET  = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_CTRL  = 2'd1;
  localparam logic [1:0] CFG_ENTRY_MODE    = 2'd2;

  // Configuration reset values
  localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
  localparam logic [7:0] DISPLAY_CTRL_RST = 8'h0C;
  localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;

  // Controller command bytes and nibbles
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_DDRAM     = 8'h80;
  localparam logic [7:0] CMD_CGRAM     = 8'h40;
  localparam logic [7:0] ROW1_BASE     = 8'h40;
  localparam logic [3:0] INIT_NIB_8BIT = 4'h3;
  localparam logic [3:0] INIT_NIB_4BIT = 4'h2;
  localparam int         INIT_WAKE_NIBS = 4;

  // Character codes
  localparam logic [7:0] ASCII_MINUS    = 8'h2D;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // Decimal conversion sizes
  localparam int MAG_W      = 32;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int CONV_CNT_W = $clog2(MAG_W);
  localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);

  // Sequence lengths in nibbles
  localparam int INIT_NIBS  = 12;
  localparam int GLYPH_NIBS = 18;
  localparam int NIB_CNT_W  = 5;

  // Default display geometry
  localparam int ROWS_DEFAULT = 2;
  localparam int COLS_DEFAULT = 16;

  // One request word
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         byte_value;
    logic [7:0]         cursor_row;
    logic [7:0]         cursor_col;
    logic signed [31:0] number;
    logic [7:0]         glyph_slot;
    logic [63:0]        glyph_rows;
  } in_t;

  // One bus nibble word
  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic [1:0] wait_after;
    logic       powerup_wait_before;
    logic       last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_step;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_is_int;
    logic conv_last;
    logic skip_done;
    logic nib_last;
  } status_t;

endpackage

>>> src/char_lcd_four_bit_sequencer.sv
// Character-LCD four-bit sequencer: one request word in, 2 to 22 nibble words out.
// Integer requests first pass through double-dabble conversion and then leading-zero
// removal before their first nibble is registered.
// Throughput: one nibble per cycle while the output is not stalled; the next request
// is accepted in the cycle after the last nibble of the current one is registered.
// Reset: asynchronous, active low; idles and restores the three init command codes.
`timescale 1ns / 1ps

module char_lcd_four_bit_sequencer #(
  parameter int ROWS = clcd_pkg::ROWS_DEFAULT,
  parameter int COLS = clcd_pkg::COLS_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  clcd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output clcd_pkg::out_t out_data_o
);
  import clcd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller
  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  clcd_dpath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // An accepted request holds off the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without holding off the next one");

  // The power-up wait only precedes a long-wait command nibble.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.powerup_wait_before |->
      (out_data_o.wait_after == WAIT_LONG) && !out_data_o.register_select)
    else $error("power-up wait on a wrong nibble");

  // Data nibbles never ask for a wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.register_select |-> out_data_o.wait_after == WAIT_NONE)
    else $error("data nibble with a wait");

  // A nibble word other than the last is only shown while its request is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("request ended before its last nibble");
`endif

endmodule

>>> src/clcd_ctrl.sv
// Sequencing controller for the character-LCD four-bit sequencer.
// Depends on clcd_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps

module clcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  clcd_pkg::status_t status_i,
  output clcd_pkg::cmd_t    cmd_o
);
  import clcd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.conv_step = (state_q == ST_CONV);
    cmd_o.skip_step = (state_q == ST_SKIP) && !status_i.skip_done;
    cmd_o.emit      = (state_q == ST_EMIT) && out_free;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = status_i.in_is_int ? ST_CONV : ST_EMIT;
      end
      ST_CONV: begin
        if (status_i.conv_last) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (status_i.skip_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && status_i.nib_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid follows loads and drains.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> src/clcd_dpath.sv
// Datapath for the character-LCD four-bit sequencer: request capture, config
// registers, double-dabble decimal conversion and nibble selection. Uses clcd_pkg.
`timescale 1ns / 1ps

module clcd_dpath #(
  parameter int ROWS = clcd_pkg::ROWS_DEFAULT,
  parameter int COLS = clcd_pkg::COLS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  clcd_pkg::in_t     in_data_i,
  input  clcd_pkg::cmd_t    cmd_i,
  output clcd_pkg::status_t status_o,
  output clcd_pkg::out_t    out_data_o
);
  import clcd_pkg::*;

  // Configuration registers
  logic [7:0] function_set_q, display_ctrl_q, entry_mode_q;

  // Request registers
  logic [2:0]             kind_q, kind_d;
  logic [7:0]             byte_q, byte_d;
  logic [7:0]             rows_q [8];
  logic [MAG_W-1:0]       mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic                   minus_q, minus_d;
  logic [CONV_CNT_W-1:0]  conv_cnt_q, conv_cnt_d;
  logic [DIG_CNT_W-1:0]   ndig_q, ndig_d;
  logic [NIB_CNT_W-1:0]   ncnt_q, ncnt_d;
  out_t                   out_q;

  // Load-time values
  logic [7:0]       load_byte;
  logic             row_sel;
  logic [7:0]       col_eff;
  logic [MAG_W-1:0] num_bits;

  // Conversion step
  logic [BCD_W-1:0] bcd_adj;

  // Current nibble
  logic [3:0] byte_idx;
  logic       half;
  logic [2:0] row_idx;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic [1:0] cur_wait_low;
  logic       cur_direct;
  logic [3:0] cur_direct_nib;
  logic       cur_last;
  out_t       cur_out;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      function_set_q <= FUNCTION_SET_RST;
      display_ctrl_q <= DISPLAY_CTRL_RST;
      entry_mode_q   <= ENTRY_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FUNCTION_SET: function_set_q <= cfg_data_i;
        CFG_DISPLAY_CTRL: display_ctrl_q <= cfg_data_i;
        CFG_ENTRY_MODE:   entry_mode_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cursor address and first byte of each request.
  assign row_sel  = (in_data_i.cursor_row < 8'(ROWS)) ? in_data_i.cursor_row[0] : 1'b0;
  assign col_eff  = (in_data_i.cursor_col < 8'(COLS)) ? in_data_i.cursor_col : 8'd0;
  assign num_bits = in_data_i.number;

  always_comb begin
    unique case (in_data_i.kind)
      KIND_CLEAR:  load_byte = CMD_CLEAR;
      KIND_HOME:   load_byte = CMD_HOME;
      KIND_CURSOR: load_byte = CMD_DDRAM | ((row_sel ? ROW1_BASE : 8'd0) + col_eff);
      KIND_GLYPH:  load_byte = CMD_CGRAM | {2'b00, in_data_i.glyph_slot[2:0], 3'b000};
      default:     load_byte = in_data_i.byte_value;
    endcase
  end

  // Double-dabble adjust: every BCD digit of five or more gains three.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                      : bcd_q[4*i +: 4];
    end
  end

  // Nibble selection for the current position in the request.
  assign byte_idx = ncnt_q[NIB_CNT_W-1:1];
  assign half     = ncnt_q[0];
  assign row_idx  = 3'(byte_idx - 4'd1);

  always_comb begin
    cur_byte       = byte_q;
    cur_rs         = 1'b0;
    cur_wait_low   = WAIT_NONE;
    cur_direct     = 1'b0;
    cur_direct_nib = INIT_NIB_8BIT;
    cur_last       = half;
    unique case (kind_q)
      KIND_INIT: begin
        cur_direct     = (ncnt_q < NIB_CNT_W'(INIT_WAKE_NIBS));
        cur_direct_nib = (ncnt_q == NIB_CNT_W'(INIT_WAKE_NIBS - 1)) ? INIT_NIB_4BIT
                                                                   : INIT_NIB_8BIT;
        unique case (byte_idx)
          4'd2:    cur_byte = function_set_q;
          4'd3:    cur_byte = display_ctrl_q;
          4'd4:    cur_byte = entry_mode_q;
          default: cur_byte = CMD_CLEAR;
        endcase
        cur_wait_low = (byte_idx == 4'd5) ? WAIT_LONG : WAIT_SHORT;
        cur_last     = (ncnt_q == NIB_CNT_W'(INIT_NIBS - 1));
      end
      KIND_CLEAR, KIND_HOME: begin
        cur_wait_low = WAIT_LONG;
      end
      KIND_CMD: begin
        cur_wait_low = WAIT_SHORT;
      end
      KIND_CHAR: begin
        cur_rs = 1'b1;
      end
      KIND_CURSOR: begin
        cur_rs = 1'b0;
      end
      KIND_INT: begin
        cur_rs   = 1'b1;
        cur_byte = minus_q ? ASCII_MINUS : {ASCII_DIGIT_HI, bcd_q[BCD_W-1 -: 4]};
        cur_last = half && !minus_q && (ndig_q == DIG_CNT_W'(1));
      end
      KIND_GLYPH: begin
        cur_rs   = (byte_idx != 4'd0);
        cur_byte = (byte_idx == 4'd0) ? byte_q : rows_q[row_idx];
        cur_last = (ncnt_q == NIB_CNT_W'(GLYPH_NIBS - 1));
      end
      default: ;
    endcase
  end

  always_comb begin
    cur_out.register_select     = cur_rs;
    cur_out.nibble              = cur_direct ? cur_direct_nib
                                  : (half ? cur_byte[3:0] : cur_byte[7:4]);
    cur_out.wait_after          = cur_direct ? WAIT_LONG
                                  : (half ? cur_wait_low : WAIT_NONE);
    cur_out.powerup_wait_before = (kind_q == KIND_INIT) && (ncnt_q == '0);
    cur_out.last                = cur_last;
  end

  // Next values of the request registers.
  always_comb begin
    kind_d     = kind_q;
    byte_d     = byte_q;
    mag_d      = mag_q;
    bcd_d      = bcd_q;
    minus_d    = minus_q;
    conv_cnt_d = conv_cnt_q;
    ndig_d     = ndig_q;
    ncnt_d     = ncnt_q;
    if (cmd_i.load) begin
      kind_d     = in_data_i.kind;
      byte_d     = load_byte;
      minus_d    = num_bits[MAG_W-1];
      mag_d      = num_bits[MAG_W-1] ? (~num_bits + MAG_W'(1)) : num_bits;
      bcd_d      = '0;
      conv_cnt_d = '0;
      ndig_d     = DIG_CNT_W'(DEC_DIGITS);
      ncnt_d     = '0;
    end else if (cmd_i.conv_step) begin
      {bcd_d, mag_d} = {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
      conv_cnt_d     = conv_cnt_q + CONV_CNT_W'(1);
    end else if (cmd_i.skip_step) begin
      bcd_d  = {bcd_q[BCD_W-5:0], 4'h0};
      ndig_d = ndig_q - DIG_CNT_W'(1);
    end else if (cmd_i.emit) begin
      ncnt_d = ncnt_q + NIB_CNT_W'(1);
      if ((kind_q == KIND_INT) && half) begin
        if (minus_q) begin
          minus_d = 1'b0;
        end else begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'h0};
          ndig_d = ndig_q - DIG_CNT_W'(1);
        end
      end
    end
  end

  // Sequencing counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_q    <= 1'b0;
      conv_cnt_q <= '0;
      ndig_q     <= '0;
      ncnt_q     <= '0;
    end else begin
      minus_q    <= minus_d;
      conv_cnt_q <= conv_cnt_d;
      ndig_q     <= ndig_d;
      ncnt_q     <= ncnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) rows_q[i] <= in_data_i.glyph_rows[8*i +: 8];
    end
    if (cmd_i.emit) out_q <= cur_out;
  end

  // Status back to the controller.
  always_comb begin
    status_o.in_is_int = (in_data_i.kind == KIND_INT);
    status_o.conv_last = (conv_cnt_q == CONV_CNT_W'(MAG_W - 1));
    status_o.skip_done = (bcd_q[BCD_W-1 -: 4] != 4'h0) || (ndig_q == DIG_CNT_W'(1));
    status_o.nib_last  = cur_last;
  end

  assign out_data_o = out_q;

endmodule

>>> tb/testbench.sv
// Self-checking bench for the four-bit character-LCD sequencer: random and directed requests,
// each nibble word checked field by field against an in-bench model of the bus sequences.
// Depends on src/clcd_pkg.sv and src/char_lcd_four_bit_sequencer.sv.
`timescale 1ns / 1ps

module testbench;
  import clcd_pkg::*;

  localparam logic       RS_COMMAND      = 1'b0;
  localparam logic       RS_DATA         = 1'b1;
  localparam logic [1:0] CFG_UNMAPPED    = 2'd3;
  localparam int         MAX_IDLE        = 19;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         FINAL_CYCLES    = 60;
  localparam int         WATCHDOG_LIMIT  = 3000;
  localparam int         DIRECTED_COUNT  = 22;

  // Expected bus nibbles, predicted from each accepted request word.
  class lcd_nibble_scoreboard;
    out_t       pending_nibbles[$];
    out_t       run_words[$];
    logic [7:0] function_set;
    logic [7:0] display_ctrl;
    logic [7:0] entry_mode;
    int         mismatches;
    int         checked;

    function new();
      function_set = FUNCTION_SET_RST;
      display_ctrl = DISPLAY_CTRL_RST;
      entry_mode   = ENTRY_MODE_RST;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_FUNCTION_SET: function_set = value;
        CFG_DISPLAY_CTRL: display_ctrl = value;
        CFG_ENTRY_MODE:   entry_mode   = value;
        default: ;
      endcase
    endfunction

    function void queue_nibble(logic rs, logic [3:0] nib, logic [1:0] pause, logic powerup);
      out_t w;
      w.register_select     = rs;
      w.nibble              = nib;
      w.wait_after          = pause;
      w.powerup_wait_before = powerup;
      w.last                = 1'b0;
      run_words.push_back(w);
    endfunction

    // A byte goes out high nibble first; only the low nibble carries the wait.
    function void queue_byte(logic rs, logic [7:0] value, logic [1:0] pause);
      queue_nibble(rs, value[7:4], WAIT_NONE, 1'b0);
      queue_nibble(rs, value[3:0], pause, 1'b0);
    endfunction

    // Signed decimal, most significant digit first; the magnitude of the most
    // negative value still fits in 32 unsigned bits.
    function void queue_decimal(logic [31:0] value);
      logic [31:0] mag;
      logic [3:0]  digits[DEC_DIGITS];
      int          count;
      mag   = value[31] ? (~value + 32'd1) : value;
      count = 0;
      do begin
        digits[count] = 4'(mag % 10);
        mag           = mag / 10;
        count++;
      end while (mag != 0 && count < DEC_DIGITS);
      if (value[31]) queue_byte(RS_DATA, ASCII_MINUS, WAIT_NONE);
      for (int i = count - 1; i >= 0; i--) begin
        queue_byte(RS_DATA, {ASCII_DIGIT_HI, digits[i]}, WAIT_NONE);
      end
    endfunction

    function void note_request(in_t req);
      int         row;
      int         col;
      logic [7:0] base;
      run_words.delete();
      case (req.kind)
        KIND_INIT: begin
          queue_nibble(RS_COMMAND, INIT_NIB_8BIT, WAIT_LONG, 1'b1);
          queue_nibble(RS_COMMAND, INIT_NIB_8BIT, WAIT_LONG, 1'b0);
          queue_nibble(RS_COMMAND, INIT_NIB_8BIT, WAIT_LONG, 1'b0);
          queue_nibble(RS_COMMAND, INIT_NIB_4BIT, WAIT_LONG, 1'b0);
          queue_byte(RS_COMMAND, function_set, WAIT_SHORT);
          queue_byte(RS_COMMAND, display_ctrl, WAIT_SHORT);
          queue_byte(RS_COMMAND, entry_mode, WAIT_SHORT);
          queue_byte(RS_COMMAND, CMD_CLEAR, WAIT_LONG);
        end
        KIND_CLEAR: queue_byte(RS_COMMAND, CMD_CLEAR, WAIT_LONG);
        KIND_HOME:  queue_byte(RS_COMMAND, CMD_HOME, WAIT_LONG);
        KIND_CMD:   queue_byte(RS_COMMAND, req.byte_value, WAIT_SHORT);
        KIND_CHAR:  queue_byte(RS_DATA, req.byte_value, WAIT_NONE);
        KIND_CURSOR: begin
          // Out-of-range coordinates fall back to the first row or column.
          row = (req.cursor_row >= ROWS_DEFAULT) ? 0 : int'(req.cursor_row);
          col = (req.cursor_col >= COLS_DEFAULT) ? 0 : int'(req.cursor_col);
          base = (row == 1) ? ROW1_BASE : 8'h00;
          queue_byte(RS_COMMAND, CMD_DDRAM | 8'(int'(base) + col), WAIT_NONE);
        end
        KIND_INT: queue_decimal(req.number);
        default: begin
          queue_byte(RS_COMMAND, CMD_CGRAM | {req.glyph_slot[2:0], 3'b000}, WAIT_NONE);
          for (int i = 0; i < 8; i++) begin
            queue_byte(RS_DATA, req.glyph_rows[8*i +: 8], WAIT_NONE);
          end
        end
      endcase
      foreach (run_words[i]) begin
        out_t w;
        w      = run_words[i];
        w.last = (i == run_words.size() - 1);
        pending_nibbles.push_back(w);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at nibble word %0d: %s", checked, what);
    endtask

    task check_word(out_t got);
      out_t want;
      checked++;
      if (pending_nibbles.size() == 0) begin
        report_mismatch($sformatf("nibble word %h arrived with nothing pending", got));
        return;
      end
      want = pending_nibbles.pop_front();
      if (got.register_select !== want.register_select)
        report_mismatch($sformatf("register_select %b, predicted %b",
                                  got.register_select, want.register_select));
      if (got.nibble !== want.nibble)
        report_mismatch($sformatf("nibble %h, predicted %h", got.nibble, want.nibble));
      if (got.wait_after !== want.wait_after)
        report_mismatch($sformatf("wait_after %0d, predicted %0d",
                                  got.wait_after, want.wait_after));
      if (got.powerup_wait_before !== want.powerup_wait_before)
        report_mismatch($sformatf("powerup_wait_before %b, predicted %b",
                                  got.powerup_wait_before, want.powerup_wait_before));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, predicted %b", got.last, want.last));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_FUNCTION_SET;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_t        in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_data_o;

  lcd_nibble_scoreboard sb = new();

  bit sender_paced     = 1'b0;
  bit receiver_paced   = 1'b0;
  bit hold_off_pending = 1'b0;
  int quiet_cycles     = 0;

  char_lcd_four_bit_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock, 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Accepted words on both channels feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o === 1'b0) sb.note_request(in_data_i);
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_word(out_data_o);
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: a random stall before each word, or one long hold-off on request.
  initial begin : result_sink
    int hold;
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold             = HOLD_OFF_CYCLES;
      end else begin
        hold = receiver_paced ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  function automatic in_t random_request();
    in_t req;
    req.kind       = 3'($urandom_range(0, 7));
    req.byte_value = 8'($urandom);
    // Mostly on-screen coordinates, with the full byte range mixed in.
    req.cursor_row = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, ROWS_DEFAULT - 1));
    req.cursor_col = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, COLS_DEFAULT - 1));
    case ($urandom_range(0, 3))
      0: req.number = $urandom;
      1: req.number = $urandom_range(0, 999);
      2: req.number = -$signed(32'($urandom_range(0, 99999)));
      default: req.number = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
    req.glyph_slot = 8'($urandom);
    req.glyph_rows = {$urandom, $urandom};
    return req;
  endfunction

  // Field extremes, every kind and the coordinate and number corner cases.
  function automatic in_t directed_request(int step);
    in_t req;
    req = random_request();
    case (step)
      0:  req.kind = KIND_INIT;
      1:  req.kind = KIND_CLEAR;
      2:  req.kind = KIND_HOME;
      3:  begin req.kind = KIND_CMD;  req.byte_value = 8'h00; end
      4:  begin req.kind = KIND_CMD;  req.byte_value = 8'hFF; end
      5:  begin req.kind = KIND_CHAR; req.byte_value = 8'h00; end
      6:  begin req.kind = KIND_CHAR; req.byte_value = 8'hFF; end
      7:  begin req.kind = KIND_CURSOR; req.cursor_row = 8'd0; req.cursor_col = 8'd0; end
      8:  begin
        req.kind       = KIND_CURSOR;
        req.cursor_row = 8'(ROWS_DEFAULT - 1);
        req.cursor_col = 8'(COLS_DEFAULT - 1);
      end
      9:  begin req.kind = KIND_CURSOR; req.cursor_row = 8'(ROWS_DEFAULT); req.cursor_col = 8'd5; end
      10: begin req.kind = KIND_CURSOR; req.cursor_row = 8'd1; req.cursor_col = 8'(COLS_DEFAULT); end
      11: begin req.kind = KIND_CURSOR; req.cursor_row = 8'hFF; req.cursor_col = 8'hFF; end
      12: begin req.kind = KIND_INT; req.number = 32'sd0; end
      13: begin req.kind = KIND_INT; req.number = -32'sd1; end
      14: begin req.kind = KIND_INT; req.number = 32'sh7FFFFFFF; end
      15: begin req.kind = KIND_INT; req.number = 32'sh80000000; end
      16: begin req.kind = KIND_INT; req.number = 32'sd1234567890; end
      17: begin req.kind = KIND_INT; req.number = 32'sd9; end
      18: begin req.kind = KIND_INT; req.number = 32'sd10; end
      19: begin req.kind = KIND_GLYPH; req.glyph_slot = 8'hFF; req.glyph_rows = '1; end
      20: begin req.kind = KIND_GLYPH; req.glyph_slot = 8'h00; req.glyph_rows = '0; end
      default: begin req.kind = KIND_GLYPH; req.glyph_slot = 8'hF8; end
    endcase
    return req;
  endfunction

  // Offers one request word and returns at the edge that accepts it; valid stays
  // high so that a back-to-back word needs no second assignment in that step.
  task automatic send_request(input in_t req);
    int gap;
    gap = sender_paced ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Stops offering and waits until every predicted nibble has come back. The first
  // edge lets the monitor note a word accepted in the step this task starts in.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_nibbles.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the three init codes, then a write to the unmapped index that must be ignored.
  task automatic program_registers(input logic [7:0] fs, input logic [7:0] dc,
                                   input logic [7:0] em);
    logic [1:0] indexes[4];
    logic [7:0] values[4];
    indexes = '{CFG_FUNCTION_SET, CFG_DISPLAY_CTRL, CFG_ENTRY_MODE, CFG_UNMAPPED};
    values  = '{fs, dc, em, 8'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= indexes[i];
      cfg_data_i <= values[i];
      sb.write_register(indexes[i], values[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(random_request());
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  // One setting of the init codes: idle, reprogram, init with the new codes, random traffic.
  task automatic run_phase(input logic [7:0] fs, input logic [7:0] dc, input logic [7:0] em,
                           input int count);
    in_t req;
    drain_results();
    program_registers(fs, dc, em);
    req      = random_request();
    req.kind = KIND_INIT;
    send_request(req);
    run_random(count);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests with the reset init codes.
    sender_paced   = 1'b1;
    receiver_paced = 1'b1;
    for (int i = 0; i < DIRECTED_COUNT; i++) send_request(directed_request(i));

    // All-zero codes: a stretch with no idling, then idling on both sides.
    sender_paced   = 1'b0;
    receiver_paced = 1'b0;
    run_phase(8'h00, 8'h00, 8'h00, 60);
    sender_paced   = 1'b1;
    receiver_paced = 1'b1;
    run_random(60);

    // All-ones codes: the receiver holds off while the sender keeps offering.
    sender_paced     = 1'b0;
    hold_off_pending = 1'b1;
    run_phase(8'hFF, 8'hFF, 8'hFF, 40);
    sender_paced   = 1'b1;
    receiver_paced = 1'b0;
    run_random(80);

    // Random codes under mixed pacing.
    receiver_paced = 1'b1;
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 100);
    sender_paced = 1'b0;
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 100);

    drain_results();
    repeat (FINAL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_nibbles.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/clcd_pkg.sv
src/clcd_ctrl.sv
src/clcd_dpath.sv
src/char_lcd_four_bit_sequencer.sv
tb/testbench.sv
